// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the blend script sequencer.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/brss_pkg.sv =====
// Package of the blend script sequencer: codes, command patterns, defaults.
// Depends on nothing; imported by blend_register_script_sequencer_unit.
`timescale 1ns / 1ps

package brss_pkg;

    localparam int DEF_SCRIPT_WORDS          = 512;
    localparam int DEF_MAX_COMMANDS_PER_TICK = 16;

    // Request kinds on the input stream.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Register targets on the output stream.
    localparam logic [1:0] TGT_CONTROL = 2'd0;
    localparam logic [1:0] TGT_ALPHA   = 2'd1;
    localparam logic [1:0] TGT_BRIGHT  = 2'd2;
    localparam logic [1:0] TGT_END     = 2'd3;

    // Status reported with each result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WAIT    = 2'd1;
    localparam logic [1:0] ST_HALT    = 2'd2;
    localparam logic [1:0] ST_RUNAWAY = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_PAUSE  = 1'b1;

    // Command word patterns.
    localparam logic [15:0] CMD_RESTART  = 16'hFFFF;
    localparam logic [15:0] MASK_HI_BYTE = 16'hFF00;
    localparam logic [15:0] CMD_JUMP     = 16'hFE00;
    localparam logic [7:0]  ARG_HALT     = 8'hFF;
    localparam logic [15:0] MASK_NIBBLE  = 16'hF000;
    localparam logic [15:0] CMD_CONTROL  = 16'h3000;
    localparam logic [7:0]  MODE_MASK    = 8'hC0;
    localparam logic [7:0]  MODE_ALPHA   = 8'h40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMD,
        S_DRD,
        S_DLY,
        S_END
    } seq_state_t;

endpackage

// ===== sv/blend_register_script_sequencer_unit.sv =====
// Top level of the blend script sequencer: script memory, sequencer FSM, output register.
// Depends on brss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// The slave stream carries requests: tuser is the request kind (load a script word,
// frame tick, restart), tdata holds the word index and the word value. Loads write the
// script memory, restarts clear the cursor and the delay; neither gives a result. A frame
// tick produces a run of register writes on the master stream, ended
// by one end-of-tick result with tlast set, whose status tells why the tick stopped.
// Script and delay words are read one at a time through the single read port of the
// script memory. A new request is taken only when the previous one is finished; a
// finished result may still sit in the output register while the next request is
// accepted. When the receiver stalls, the result stays in the output register and
// the sequencer waits in front of its next result. Reset clears the cursor, delay,
// control mode, configuration and both streams; the script memory itself is not
// cleared and has to be loaded before a tick reads it. Configuration writes take
// effect at once and are meant for times when no request is in flight.
module blend_register_script_sequencer_unit
    import brss_pkg::*;
#(
    parameter int SCRIPT_WORDS          = DEF_SCRIPT_WORDS,
    parameter int MAX_COMMANDS_PER_TICK = DEF_MAX_COMMANDS_PER_TICK
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [8:0] word_index, [24:9] word_value, rest zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [15:0] write_value, [17:16] tick_status, rest zero
    output logic [1:0]  m_axis_tuser,  // [1:0] write_target
    output logic        m_axis_tlast   // last_of_tick
);

    localparam int AW    = $clog2(SCRIPT_WORDS);
    localparam int CNT_W = $clog2(MAX_COMMANDS_PER_TICK + 1);
    localparam logic [AW:0]      WORDS_EXT = (AW + 1)'(SCRIPT_WORDS);
    localparam logic [AW-1:0]    LAST_POS  = AW'(SCRIPT_WORDS - 1);
    localparam logic [CNT_W-1:0] CMD_LIMIT = CNT_W'(MAX_COMMANDS_PER_TICK);

    // Jump target 2*arg reduced modulo the store size by restoring subtraction.
    // SCRIPT_WORDS must be at least 16, which the block does not check, so 2*arg stays below 32 multiples of it.
    function automatic logic [AW-1:0] jump_pos(input logic [7:0] arg);
        logic [16:0] v;
        v = {8'd0, arg, 1'b0};
        for (int k = 4; k >= 0; k--) begin
            if (v >= (17'(SCRIPT_WORDS) << k))
            begin
                v = v - (17'(SCRIPT_WORDS) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // Request fields.
    logic [1:0]  in_req;
    logic [8:0]  in_index;
    logic [15:0] in_value;
    logic        in_accept;

    assign in_req    = s_axis_tuser;
    assign in_index  = s_axis_tdata[8:0];
    assign in_value  = s_axis_tdata[24:9];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Configuration.
    logic enable_reg;
    logic pause_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            pause_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data;
                CFG_PAUSE:  pause_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer state.
    seq_state_t       state_reg, state_next;
    logic [AW-1:0]    cursor_reg, cursor_next;
    logic [15:0]      delay_reg, delay_next;
    logic [7:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       end_status_reg, end_status_next;

    // Script memory with a registered read port.
    logic [15:0]   script_mem [SCRIPT_WORDS];
    logic [15:0]   rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    assign mem_we = in_accept && (in_req == REQ_LOAD)
                    && (32'(in_index) < 32'(SCRIPT_WORDS));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            script_mem[AW'(in_index)] <= in_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= script_mem[rd_addr];
        end
    end

    // Neighbor positions of the cursor, wrapped at the store end.
    logic [AW-1:0] cursor_plus1;
    logic [AW:0]   cursor_sum2;
    logic [AW-1:0] cursor_plus2;

    assign cursor_plus1 = (cursor_reg == LAST_POS) ? '0 : cursor_reg + AW'(1);
    assign cursor_sum2  = {1'b0, cursor_reg} + (AW + 1)'(2);
    assign cursor_plus2 = (cursor_sum2 >= WORDS_EXT) ? AW'(cursor_sum2 - WORDS_EXT)
                                                     : cursor_sum2[AW-1:0];

    // Command decode of the word just read.
    logic [15:0] cmd;
    logic        cmd_restart;
    logic        cmd_jump_class;
    logic        cmd_halt;
    logic        cmd_control;

    assign cmd            = rd_data_reg;
    assign cmd_restart    = (cmd == CMD_RESTART);
    assign cmd_jump_class = ((cmd & MASK_HI_BYTE) == CMD_JUMP);
    assign cmd_halt       = cmd_jump_class && (cmd[7:0] == ARG_HALT);
    assign cmd_control    = ((cmd & MASK_NIBBLE) == CMD_CONTROL);

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  out_target_reg;
    logic [15:0] out_value_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;
    logic        slot_free;

    logic        emit_req;
    logic [1:0]  emit_target;
    logic [15:0] emit_value;
    logic [1:0]  emit_status;
    logic        emit_last;
    logic        emit_ok;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign emit_ok   = emit_req && slot_free;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_req == REQ_TICK))
                begin
                    if (!enable_reg || pause_reg || (delay_reg != 16'd0))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = (count_reg >= CMD_LIMIT) ? S_END : S_CMD;
            end
            S_CMD:
            begin
                if (cmd_restart || (cmd_jump_class && !cmd_halt))
                begin
                    state_next = S_READ;
                end
                else if (cmd_halt)
                begin
                    state_next = S_END;
                end
                else if (emit_ok)
                begin
                    state_next = cmd_control ? S_READ : S_DRD;
                end
            end
            S_DRD:
            begin
                state_next = S_DLY;
            end
            S_DLY:
            begin
                state_next = (rd_data_reg != 16'd0) ? S_END : S_READ;
            end
            S_END:
            begin
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory reads and result requests.
    always_comb
    begin
        cursor_next     = cursor_reg;
        delay_next      = delay_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        end_status_next = end_status_reg;
        rd_en           = 1'b0;
        rd_addr         = cursor_reg;
        emit_req        = 1'b0;
        emit_target     = TGT_END;
        emit_value      = 16'd0;
        emit_status     = ST_OK;
        emit_last       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_req == REQ_RESTART))
                begin
                    cursor_next = '0;
                    delay_next  = 16'd0;
                end
                else if (in_accept && (in_req == REQ_TICK))
                begin
                    count_next      = '0;
                    end_status_next = ST_WAIT;
                    // A pending delay is only counted down while enabled and not paused.
                    if (enable_reg && !pause_reg && (delay_reg != 16'd0))
                    begin
                        delay_next = delay_reg - 16'd1;
                    end
                end
            end
            S_READ:
            begin
                if (count_reg >= CMD_LIMIT)
                begin
                    end_status_next = ST_RUNAWAY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_CMD:
            begin
                if (cmd_restart)
                begin
                    cursor_next = '0;
                end
                else if (cmd_halt)
                begin
                    end_status_next = ST_HALT;
                end
                else if (cmd_jump_class)
                begin
                    cursor_next = jump_pos(cmd[7:0]);
                end
                else if (cmd_control)
                begin
                    emit_req    = 1'b1;
                    emit_target = TGT_CONTROL;
                    emit_value  = cmd;
                    if (slot_free)
                    begin
                        mode_next   = cmd[7:0];
                        cursor_next = cursor_plus1;
                    end
                end
                else
                begin
                    emit_req    = 1'b1;
                    emit_target = ((mode_reg & MODE_MASK) == MODE_ALPHA) ? TGT_ALPHA
                                                                         : TGT_BRIGHT;
                    emit_value  = cmd;
                end
            end
            S_DRD:
            begin
                rd_en   = 1'b1;
                rd_addr = cursor_plus1;
            end
            S_DLY:
            begin
                cursor_next = cursor_plus2;
                if (rd_data_reg != 16'd0)
                begin
                    delay_next      = rd_data_reg - 16'd1;
                    end_status_next = ST_WAIT;
                end
                else
                begin
                    delay_next = 16'd0;
                end
            end
            S_END:
            begin
                emit_req    = 1'b1;
                emit_target = TGT_END;
                emit_status = end_status_reg;
                emit_last   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_reg     <= '0;
            delay_reg      <= 16'd0;
            mode_reg       <= 8'd0;
            count_reg      <= '0;
            end_status_reg <= ST_WAIT;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            delay_reg      <= delay_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            end_status_reg <= end_status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ok)
        begin
            out_target_reg <= emit_target;
            out_value_reg  <= emit_value;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_value_reg};
    assign m_axis_tuser  = out_target_reg;
    assign m_axis_tlast  = out_last_reg;

    // The command count of a tick never passes the limit.
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CMD_LIMIT)
    // The cursor always points inside the script memory.
    `ASSERT_SAME(a_cursor_bound, clk, rst_n, 1'b1, {1'b0, cursor_reg} < WORDS_EXT)
    // Only the end-of-tick result carries tlast, and it always does.
    `ASSERT_SAME(a_last_is_end, clk, rst_n, m_axis_tvalid,
        m_axis_tlast == (m_axis_tuser == TGT_END))
    // A tick while disabled goes straight to its end result.
    `ASSERT_NEXT(a_idle_tick, clk, rst_n, in_accept && (in_req == REQ_TICK) && !enable_reg,
        state_reg == S_END)

endmodule
